/* hdl/lceb_pkg.sv */
// Package with the sizes, request codes, controller states and command types of the edit buffer.
`default_nettype none
package lceb_pkg;

  localparam int LCEB_DEPTH  = 64;
  localparam int LCEB_ADDR_W = $clog2(LCEB_DEPTH);
  localparam int LCEB_CNT_W  = $clog2(LCEB_DEPTH + 1);
  localparam int LCEB_CHAR_W = 8;
  localparam int LCEB_REQ_W  = 3;

  typedef logic [LCEB_CNT_W-1:0]  cnt_t;
  typedef logic [LCEB_ADDR_W-1:0] addr_t;
  typedef logic [LCEB_CHAR_W-1:0] char_t;

  typedef enum logic [LCEB_REQ_W-1:0] {
    REQ_INSERT = 3'd0,
    REQ_LEFT   = 3'd1,
    REQ_RIGHT  = 3'd2,
    REQ_BACK   = 3'd3,
    REQ_FLUSH  = 3'd4
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOVE_L,
    ST_MOVE_R,
    ST_SHOW,
    ST_EMPTY
  } state_t;

  typedef struct packed {
    logic push_left;
    logic push_right;
    logic wsrc_ram;
    logic rd_left_top;
    logic rd_right_top;
    logic dec_left;
    logic set_ovf;
    logic flush_start;
    logic flush_step;
    logic flush_clear;
    logic emit_empty;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic lc_zero;
    logic rc_zero;
    logic empty;
    logic at_last;
  } status_t;

endpackage
`default_nettype wire

/* hdl/lceb_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module lceb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* hdl/lceb_datapath.sv */
// Datapath with the two text stacks, their counts, the overflow flag and the flush walk.
`default_nettype none
module lceb_datapath
  import lceb_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire cmd_t    cmd,
  input  wire char_t   char_in,
  output status_t      status,
  output char_t        text_char,
  output logic         char_valid,
  output logic         last,
  output logic         overflow
);

  cnt_t  lc_r, lc_nxt;
  cnt_t  rc_r, rc_nxt;
  logic  ovf_r, ovf_nxt;
  cnt_t  pos_r;
  logic  sel_r;

  cnt_t  total;
  cnt_t  lc_m1;
  cnt_t  rc_m1;
  cnt_t  p;
  cnt_t  r_idx;
  logic  left_side;
  logic  flush_rd;

  logic  l_we, l_re, r_we, r_re;
  addr_t l_raddr, r_raddr;
  char_t l_wdata, l_rdata, r_rdata;

  assign total     = lc_r + rc_r;
  assign lc_m1     = lc_r - cnt_t'(1);
  assign rc_m1     = rc_r - cnt_t'(1);
  assign flush_rd  = cmd.flush_start | cmd.flush_step;
  assign p         = cmd.flush_start ? '0 : pos_r + cnt_t'(1);
  assign left_side = p < lc_r;
  assign r_idx     = total - cnt_t'(1) - p;

  assign l_we    = cmd.push_left;
  assign l_wdata = cmd.wsrc_ram ? r_rdata : char_in;
  assign l_re    = cmd.rd_left_top | (flush_rd & left_side);
  assign l_raddr = cmd.rd_left_top ? lc_m1[LCEB_ADDR_W-1:0] : p[LCEB_ADDR_W-1:0];

  assign r_we    = cmd.push_right;
  assign r_re    = cmd.rd_right_top | (flush_rd & ~left_side);
  assign r_raddr = cmd.rd_right_top ? rc_m1[LCEB_ADDR_W-1:0] : r_idx[LCEB_ADDR_W-1:0];

  lceb_ram #(
    .WIDTH(LCEB_CHAR_W),
    .DEPTH(LCEB_DEPTH)
  ) u_left_ram (
    .clk  (clk),
    .we   (l_we),
    .waddr(lc_r[LCEB_ADDR_W-1:0]),
    .wdata(l_wdata),
    .re   (l_re),
    .raddr(l_raddr),
    .rdata(l_rdata)
  );

  lceb_ram #(
    .WIDTH(LCEB_CHAR_W),
    .DEPTH(LCEB_DEPTH)
  ) u_right_ram (
    .clk  (clk),
    .we   (r_we),
    .waddr(rc_r[LCEB_ADDR_W-1:0]),
    .wdata(l_rdata),
    .re   (r_re),
    .raddr(r_raddr),
    .rdata(r_rdata)
  );

  always_comb begin
    lc_nxt  = lc_r;
    rc_nxt  = rc_r;
    ovf_nxt = ovf_r;
    if (cmd.flush_clear) begin
      lc_nxt  = '0;
      rc_nxt  = '0;
      ovf_nxt = 1'b0;
    end else begin
      if (cmd.push_left) begin
        lc_nxt = lc_r + cnt_t'(1);
      end else if (cmd.rd_left_top || cmd.dec_left) begin
        lc_nxt = lc_m1;
      end
      if (cmd.push_right) begin
        rc_nxt = rc_r + cnt_t'(1);
      end else if (cmd.rd_right_top) begin
        rc_nxt = rc_m1;
      end
      if (cmd.set_ovf) begin
        ovf_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lc_r  <= '0;
      rc_r  <= '0;
      ovf_r <= 1'b0;
    end else begin
      lc_r  <= lc_nxt;
      rc_r  <= rc_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (flush_rd) begin
      pos_r <= p;
      sel_r <= left_side;
    end
  end

  assign status.full    = total == cnt_t'(LCEB_DEPTH);
  assign status.lc_zero = lc_r == '0;
  assign status.rc_zero = rc_r == '0;
  assign status.empty   = total == '0;
  assign status.at_last = pos_r == total - cnt_t'(1);

  assign text_char  = cmd.emit_empty ? '0 : (sel_r ? l_rdata : r_rdata);
  assign char_valid = ~cmd.emit_empty;
  assign last       = cmd.emit_empty | status.at_last;
  assign overflow   = ovf_r;

endmodule
`default_nettype wire

/* hdl/lceb_ctrl.sv */
// Controller state machine that decodes requests and sequences moves and flush runs.
`default_nettype none
module lceb_ctrl
  import lceb_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  input  wire logic [LCEB_REQ_W-1:0] req_type,
  output logic                       in_ready,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  input  wire status_t               status,
  output cmd_t                       cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (req_t'(req_type))
            REQ_INSERT: begin
              if (status.full) begin
                cmd.set_ovf = 1'b1;
              end else begin
                cmd.push_left = 1'b1;
              end
            end
            REQ_LEFT: begin
              if (!status.lc_zero) begin
                cmd.rd_left_top = 1'b1;
                state_nxt       = ST_MOVE_L;
              end
            end
            REQ_RIGHT: begin
              if (!status.rc_zero) begin
                cmd.rd_right_top = 1'b1;
                state_nxt        = ST_MOVE_R;
              end
            end
            REQ_BACK: begin
              if (!status.lc_zero) begin
                cmd.dec_left = 1'b1;
              end
            end
            REQ_FLUSH: begin
              if (status.empty) begin
                state_nxt = ST_EMPTY;
              end else begin
                cmd.flush_start = 1'b1;
                state_nxt       = ST_SHOW;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_MOVE_L: begin
        cmd.push_right = 1'b1;
        state_nxt      = ST_IDLE;
      end
      ST_MOVE_R: begin
        cmd.push_left = 1'b1;
        cmd.wsrc_ram  = 1'b1;
        state_nxt     = ST_IDLE;
      end
      ST_SHOW: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (status.at_last) begin
            cmd.flush_clear = 1'b1;
            state_nxt       = ST_IDLE;
          end else begin
            cmd.flush_step = 1'b1;
          end
        end
      end
      ST_EMPTY: begin
        out_valid      = 1'b1;
        cmd.emit_empty = 1'b1;
        if (out_ready) begin
          cmd.flush_clear = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

/* hdl/cursor_line_edit_buffer.sv */
// Top level of the cursor line-edit buffer: controller plus stack datapath.
// Requests arrive on the in_ stream: in_tuser holds the request code, in_tdata the byte to
// insert. Insert, backspace and ignored requests are done on acceptance; a cursor move goes
// through a move state, as the top byte of one stack is read and written to the other stack.
// A flush produces the whole text on the out_ stream, first byte to last, with out_tlast on
// the final transfer; the first byte is shown the cycle after the flush is accepted and the
// following bytes follow one per cycle while the receiver takes them.
// An empty buffer flushes as one transfer with char_valid low and out_tlast high.
// While a flush run or a move is under way in_tready is low. When the receiver stalls the
// current byte is held on the RAM output register until it is taken.
// Reset clears both counts, the overflow flag and the controller; stack contents are not
// cleared, since only bytes below a count are ever read.
`default_nettype none
module cursor_line_edit_buffer
  import lceb_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [7:0]            in_tdata,  // [7:0] char_in
  input  wire logic [LCEB_REQ_W-1:0] in_tuser,  // [2:0] req_type
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic      [7:0]            out_tdata, // [7:0] text_char
  output logic      [1:0]            out_tuser, // [0] char_valid, [1] overflow
  output logic                       out_tlast
);

  cmd_t    cmd;
  status_t status;
  logic    char_valid;
  logic    overflow;

  lceb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .req_type (in_tuser),
    .in_ready (in_tready),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .status   (status),
    .cmd      (cmd)
  );

  lceb_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .char_in   (in_tdata),
    .status    (status),
    .text_char (out_tdata),
    .char_valid(char_valid),
    .last      (out_tlast),
    .overflow  (overflow)
  );

  assign out_tuser = {overflow, char_valid};

endmodule
`default_nettype wire

/* tb/sv/lceb_text_checker.sv */
`timescale 1ns / 100ps
// Checker for the cursor line-edit buffer: it tracks the text and compares each flushed byte.
module lceb_text_checker
  import lceb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [7:0]            in_tdata,
  input  logic [LCEB_REQ_W-1:0] in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [7:0]            out_tdata,
  input  logic [1:0]            out_tuser,
  input  logic                  out_tlast,
  output int                    n_errors,
  output int                    n_pending
);

  typedef struct packed {
    char_t ch;
    logic  valid;
    logic  fin;
    logic  ovf;
  } text_byte_t;

  char_t      left_text [LCEB_DEPTH];
  char_t      right_text[LCEB_DEPTH];
  int         left_len;
  int         right_len;
  logic       dropped;
  text_byte_t flush_q[$];

  initial begin
    n_errors  = 0;
    n_pending = 0;
    left_len  = 0;
    right_len = 0;
    dropped   = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    if (n_errors < 100) begin
      $display("ERROR at %0t ns: %s", $time, msg);
    end
    n_errors++;
  endtask

  task automatic edit_text(input logic [LCEB_REQ_W-1:0] req, input char_t ch);
    int total;
    int k;
    total = left_len + right_len;
    case (req)
      REQ_INSERT: begin
        if (total < LCEB_DEPTH) begin
          left_text[left_len] = ch;
          left_len++;
        end else begin
          dropped = 1'b1;
        end
      end
      REQ_LEFT: begin
        if (left_len > 0 && right_len < LCEB_DEPTH) begin
          left_len--;
          right_text[right_len] = left_text[left_len];
          right_len++;
        end
      end
      REQ_RIGHT: begin
        if (right_len > 0 && left_len < LCEB_DEPTH) begin
          right_len--;
          left_text[left_len] = right_text[right_len];
          left_len++;
        end
      end
      REQ_BACK: begin
        if (left_len > 0) begin
          left_len--;
        end
      end
      REQ_FLUSH: begin
        if (total == 0) begin
          flush_q.push_back('{'0, 1'b0, 1'b1, dropped});
        end else begin
          k = 0;
          for (int i = 0; i < left_len; i++) begin
            k++;
            flush_q.push_back('{left_text[i], 1'b1, k == total, dropped});
          end
          for (int i = right_len - 1; i >= 0; i--) begin
            k++;
            flush_q.push_back('{right_text[i], 1'b1, k == total, dropped});
          end
        end
        left_len  = 0;
        right_len = 0;
        dropped   = 1'b0;
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk) begin
    text_byte_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (flush_q.size() == 0) begin
          report_mismatch($sformatf("unexpected transfer, byte %02h user %b last %b",
                                    out_tdata, out_tuser, out_tlast));
        end else begin
          want = flush_q.pop_front();
          if (out_tdata !== want.ch)
            report_mismatch($sformatf("text_char %02h, expected %02h", out_tdata, want.ch));
          if (out_tuser[0] !== want.valid)
            report_mismatch($sformatf("char_valid %b, expected %b", out_tuser[0], want.valid));
          if (out_tuser[1] !== want.ovf)
            report_mismatch($sformatf("overflow %b, expected %b", out_tuser[1], want.ovf));
          if (out_tlast !== want.fin)
            report_mismatch($sformatf("last %b, expected %b", out_tlast, want.fin));
        end
      end
      if (in_tvalid && in_tready) begin
        edit_text(in_tuser, in_tdata);
      end
    end
    n_pending = flush_q.size();
  end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// Testbench top for the cursor line-edit buffer: request stimulus, receiver stalls and verdict.
module tb;
  import lceb_pkg::*;

  localparam logic [LCEB_REQ_W-1:0] REQ_CODE_MAX = '1;
  localparam int HOLD_LEN = 300;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [7:0]            in_tdata;
  logic [LCEB_REQ_W-1:0] in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [7:0]            out_tdata;
  logic [1:0]            out_tuser;
  logic                  out_tlast;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_reqs = 0;
  int items_sent = 0;
  int n_errors;
  int n_pending;

  cursor_line_edit_buffer u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  lceb_text_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .n_errors   (n_errors),
    .n_pending  (n_pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

  // The receiver owns its hold-off counter; the stimulus only asks for a hold.
  initial begin : receiver
    int hold_done;
    int hold_cnt;
    hold_done = 0;
    hold_cnt  = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_reqs != hold_done) begin
        hold_done = hold_reqs;
        hold_cnt  = HOLD_LEN;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_req(input logic [LCEB_REQ_W-1:0] req, input char_t ch);
    bit ready_seen;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= ch;
    do begin
      @(negedge clk);
      ready_seen = in_tready;
      @(posedge clk);
    end while (!ready_seen);
    items_sent++;
  endtask

  // One line of typing ended by a flush. A fill line inserts more bytes than the buffer holds.
  task automatic type_line(input bit fill, input bit hold_flush);
    int inserts;
    int pick;
    if (fill) begin
      inserts = 0;
      while (inserts <= LCEB_DEPTH + 2) begin
        pick = $urandom_range(99);
        if (pick < 80) begin
          send_req(REQ_INSERT, char_t'($urandom()));
          inserts++;
        end else if (pick < 90) begin
          send_req(REQ_LEFT, char_t'($urandom()));
        end else begin
          send_req(REQ_RIGHT, char_t'($urandom()));
        end
      end
      repeat ($urandom_range(0, 10)) send_req(REQ_LEFT, char_t'($urandom()));
    end else begin
      repeat ($urandom_range(1, 14)) begin
        pick = $urandom_range(99);
        if (pick < 45) begin
          send_req(REQ_INSERT, char_t'($urandom()));
        end else if (pick < 60) begin
          send_req(REQ_LEFT, char_t'($urandom()));
        end else if (pick < 75) begin
          send_req(REQ_RIGHT, char_t'($urandom()));
        end else if (pick < 88) begin
          send_req(REQ_BACK, char_t'($urandom()));
        end else if (pick < 94) begin
          send_req(LCEB_REQ_W'($urandom_range(REQ_FLUSH + 1, REQ_CODE_MAX)),
                   char_t'($urandom()));
        end else begin
          send_req(REQ_FLUSH, char_t'($urandom()));
        end
      end
    end
    if (hold_flush) begin
      hold_reqs++;
    end
    send_req(REQ_FLUSH, char_t'($urandom()));
  endtask

  initial begin
    int phase_end;
    int line_no;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= REQ_INSERT;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 12;
    recv_idle_pct = 50;
    send_req(REQ_FLUSH, 8'h00);
    send_req(REQ_LEFT, 8'hFF);
    send_req(REQ_BACK, 8'hFF);
    send_req(REQ_RIGHT, 8'hFF);
    send_req(REQ_INSERT, 8'h00);
    send_req(REQ_INSERT, 8'hFF);
    send_req(REQ_INSERT, 8'hA5);
    send_req(REQ_LEFT, 8'h00);
    send_req(REQ_LEFT, 8'h00);
    send_req(REQ_INSERT, 8'h5A);
    send_req(REQ_RIGHT, 8'h00);
    send_req(REQ_BACK, 8'h00);
    send_req(REQ_RIGHT, 8'h00);
    send_req(REQ_RIGHT, 8'h00);
    for (int c = REQ_FLUSH + 1; c <= REQ_CODE_MAX; c++) begin
      send_req(LCEB_REQ_W'(c), 8'h3C);
    end
    send_req(REQ_FLUSH, 8'hFF);
    send_req(REQ_INSERT, 8'h7E);
    send_req(REQ_LEFT, 8'h81);
    send_req(REQ_FLUSH, 8'h00);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 12 : (phase == 1) ? 50 : 0;
      recv_idle_pct = (phase == 0) ? 50 : (phase == 1) ? 12 : 0;
      phase_end = items_sent + 128;
      line_no = 0;
      while (items_sent < phase_end) begin
        type_line(line_no % 5 == 1, phase == 0 && line_no == 1);
        line_no++;
      end
    end
    in_tvalid <= 1'b0;

    do @(negedge clk); while (n_pending != 0);
    repeat (20) @(posedge clk);
    if (n_errors == 0 && n_pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/lceb_pkg.sv
hdl/lceb_ram.sv
hdl/lceb_datapath.sv
hdl/lceb_ctrl.sv
hdl/cursor_line_edit_buffer.sv
tb/sv/lceb_text_checker.sv
tb/sv/tb.sv
